FILE: src/bpa_pkg.sv
// bpa_pkg: shared widths, request and status codes, controller/datapath bundles
// for the bitmap page allocator; no dependencies

package bpa_pkg;

   localparam int MODE_W = 3;
   localparam int PIDX_W = 12;
   localparam int ADDR_W = 32;
   localparam int STAT_W = 2;
   localparam int CNT_W  = 13;
   localparam int BYTE_W = 8;
   localparam int CSR_AW = 4;
   localparam int CSR_DW = 32;

   // request modes
   localparam logic [MODE_W-1:0] MODE_CLEAR     = 3'd0;
   localparam logic [MODE_W-1:0] MODE_MARK      = 3'd1;
   localparam logic [MODE_W-1:0] MODE_ALLOC     = 3'd2;
   localparam logic [MODE_W-1:0] MODE_ALLOC_RSV = 3'd3;
   localparam logic [MODE_W-1:0] MODE_FREE      = 3'd4;

   // result status codes
   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_NONE  = 2'd1;
   localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

   // register indexes (paddr[3:2])
   localparam logic [1:0] REG_BASE    = 2'd0;
   localparam logic [1:0] REG_PAGES   = 2'd1;
   localparam logic [1:0] REG_RESERVE = 2'd2;

   localparam logic [CNT_W-1:0] PAGE_COUNT_RST = 13'd4096;

   typedef struct packed {
      logic load;
      logic decode;
      logic sweep;
      logic rd_target;
      logic wr_target;
      logic search_issue;
      logic search_take;
      logic search_none;
      logic rsp_load;
   } bpa_cmd_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic dec_ok;
      logic dec_empty;
      logic sweep_last;
      logic issue_done;
      logic hit;
      logic chk_vld;
      logic rsp_free;
   } bpa_sts_type;

endpackage

FILE: src/bpa_if.sv
// bpa_req_if, bpa_rsp_if: valid/ready channels of the bitmap page allocator
// depends on bpa_pkg

interface bpa_req_if import bpa_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] mode;
   logic [PIDX_W-1:0] page_index;
   logic [ADDR_W-1:0] address;

   modport source (output valid, mode, page_index, address, input ready);
   modport sink (input valid, mode, page_index, address, output ready);
endinterface

interface bpa_rsp_if import bpa_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [STAT_W-1:0] status;
   logic [ADDR_W-1:0] page_address;
   logic [PIDX_W-1:0] page_number;

   modport source (output valid, status, page_address, page_number, input ready);
   modport sink (input valid, status, page_address, page_number, output ready);
endinterface

FILE: src/bpa_ram.sv
// bpa_ram: generic single write port, single read port ram with registered read
// no dependencies

module bpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic                                         rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/bpa_ctrl.sv
// bpa_ctrl: sequencing state machine of the bitmap page allocator
// depends on bpa_pkg; drives bpa_datapath through bpa_cmd_type

module bpa_ctrl import bpa_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output bpa_cmd_type cmd,
   input  bpa_sts_type sts
);

   localparam logic [2:0] S_INIT   = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_DECODE = 3'd2;
   localparam logic [2:0] S_CLEAR  = 3'd3;
   localparam logic [2:0] S_RD     = 3'd4;
   localparam logic [2:0] S_WR     = 3'd5;
   localparam logic [2:0] S_SEARCH = 3'd6;
   localparam logic [2:0] S_RESP   = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       accept;

   assign accept = req_valid && req_ready;

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      state_in  = state_ff;
      case (state_ff)
         S_INIT: begin
            cmd.sweep = 1'b1;
            if (sts.sweep_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.decode = 1'b1;
            case (sts.mode)
               MODE_CLEAR: state_in = S_CLEAR;
               MODE_MARK, MODE_FREE: state_in = sts.dec_ok ? S_RD : S_RESP;
               MODE_ALLOC, MODE_ALLOC_RSV: state_in = sts.dec_empty ? S_RESP : S_SEARCH;
               default: state_in = S_RESP;
            endcase
         end
         S_CLEAR: begin
            cmd.sweep = 1'b1;
            if (sts.sweep_last) begin
               state_in = S_RESP;
            end
         end
         S_RD: begin
            cmd.rd_target = 1'b1;
            state_in      = S_WR;
         end
         S_WR: begin
            cmd.wr_target = 1'b1;
            state_in      = S_RESP;
         end
         S_SEARCH: begin
            if (sts.hit) begin
               cmd.search_take = 1'b1;
               state_in        = S_RESP;
            end else if (!sts.issue_done) begin
               cmd.search_issue = 1'b1;
            end else if (!sts.chk_vld) begin
               cmd.search_none = 1'b1;
               state_in        = S_RESP;
            end
         end
         S_RESP: begin
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_INIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   a_accept_decodes: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_DECODE)
      else $error("accepted transaction not decoded next cycle");

   a_rsp_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> sts.rsp_free)
      else $error("result loaded over a pending transaction");

   a_take_on_hit: assert property (@(posedge clock) disable iff (reset)
      cmd.search_take |-> sts.hit && sts.chk_vld)
      else $error("search took a byte without a free page");

   a_rmw_order: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_target |-> $past(cmd.rd_target))
      else $error("bitmap update without a preceding read");

endmodule

FILE: src/bpa_datapath.sv
// bpa_datapath: bitmap ram, range bounds, byte scan and result register
// depends on bpa_pkg and bpa_ram; commanded by bpa_ctrl

module bpa_datapath import bpa_pkg::*; #(
   parameter int MAX_PAGES      = 4096,
   parameter int PAGE_SIZE_LOG2 = 12
) (
   input  logic              clock,
   input  logic              reset,
   input  bpa_cmd_type       cmd,
   output bpa_sts_type       sts,
   input  logic [MODE_W-1:0] req_mode,
   input  logic [PIDX_W-1:0] req_page_index,
   input  logic [ADDR_W-1:0] req_address,
   input  logic [ADDR_W-1:0] base_address,
   input  logic [CNT_W-1:0]  page_count,
   input  logic [CNT_W-1:0]  reserve_count,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [STAT_W-1:0] rsp_status,
   output logic [ADDR_W-1:0] rsp_page_address,
   output logic [PIDX_W-1:0] rsp_page_number
);

   localparam int DEPTH = (MAX_PAGES + 7) / 8;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int BW    = AW + 1;
   localparam int PGW   = AW + 3;
   localparam int CW    = $clog2(MAX_PAGES + 1);
   localparam int EW    = (CW > CNT_W) ? CW : CNT_W;
   localparam logic [EW-1:0] MAX_E     = EW'(MAX_PAGES);
   localparam logic [BW-1:0] LAST_BYTE = BW'(DEPTH - 1);

   // request and bounds
   logic [MODE_W-1:0] mode_ff;
   logic [PIDX_W-1:0] pidx_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [EW-1:0]     eff_ff;
   logic [EW-1:0]     effr_ff;
   logic [EW-1:0]     pc_e;
   logic [EW-1:0]     rc_e;
   logic [EW-1:0]     eff_in;
   logic [EW-1:0]     effr_in;

   // scan state
   logic [PGW-1:0]    page_ff;
   logic [BW-1:0]     cur_ff;
   logic [BW-1:0]     last_ff;
   logic [BW-1:0]     lo_byte_ff;
   logic [2:0]        lo_bit_ff;
   logic [2:0]        hi_bit_ff;
   logic [BW-1:0]     chk_byte_ff;
   logic              chk_vld_ff;

   // result
   logic [STAT_W-1:0] res_status_ff;
   logic              res_has_ff;
   logic              rsp_valid_ff;
   logic [STAT_W-1:0] rsp_status_ff;
   logic [ADDR_W-1:0] rsp_addr_ff;
   logic [PIDX_W-1:0] rsp_page_ff;

   // decode
   logic [EW-1:0]     lo;
   logic [EW-1:0]     hi;
   logic [EW-1:0]     hm1;
   logic              empty;
   logic [ADDR_W-1:0] diff;
   logic [ADDR_W-1:0] free_pg;
   logic              free_ok;
   logic              mark_ok;
   logic              dec_ok;
   logic [PGW-1:0]    tgt_pg;
   logic              is_alloc;

   // byte check
   logic [BYTE_W-1:0] mask;
   logic [BYTE_W-1:0] free_vec;
   logic [2:0]        hit_bit;
   logic              hit;
   logic [PGW-1:0]    found_pg;
   logic [BYTE_W-1:0] tgt_bit;

   // ram ports
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [BYTE_W-1:0] wr_data;
   logic              rd_en;
   logic [AW-1:0]     rd_addr;
   logic [BYTE_W-1:0] rd_data;

   assign pc_e    = EW'(page_count);
   assign rc_e    = EW'(reserve_count);
   assign eff_in  = (pc_e > MAX_E) ? MAX_E : pc_e;
   assign effr_in = (rc_e > eff_in) ? eff_in : rc_e;

   assign is_alloc = (mode_ff == MODE_ALLOC) || (mode_ff == MODE_ALLOC_RSV);
   assign lo       = (mode_ff == MODE_ALLOC) ? effr_ff : '0;
   assign hi       = (mode_ff == MODE_ALLOC) ? eff_ff : effr_ff;
   assign empty    = lo >= hi;
   assign hm1      = hi - EW'(1);

   assign diff    = addr_ff - base_address;
   assign free_pg = diff >> PAGE_SIZE_LOG2;
   assign free_ok = (addr_ff >= base_address) && (free_pg < ADDR_W'(eff_ff));
   assign mark_ok = EW'(pidx_ff) < eff_ff;
   assign dec_ok  = (mode_ff == MODE_MARK) ? mark_ok : free_ok;
   assign tgt_pg  = (mode_ff == MODE_MARK) ? PGW'(pidx_ff) : PGW'(free_pg);

   // only pages inside [lo, hi) of the checked byte take part
   always_comb begin
      for (int j = 0; j < BYTE_W; j++) begin
         mask[j] = ((chk_byte_ff != lo_byte_ff) || (3'(j) >= lo_bit_ff)) &&
                   ((chk_byte_ff != last_ff) || (3'(j) <= hi_bit_ff));
      end
   end

   assign free_vec = ~rd_data & mask;
   assign hit      = chk_vld_ff && (|free_vec);

   always_comb begin
      hit_bit = '0;
      for (int j = BYTE_W - 1; j >= 0; j--) begin
         if (free_vec[j]) begin
            hit_bit = 3'(j);
         end
      end
   end

   assign found_pg = {chk_byte_ff[AW-1:0], hit_bit};
   assign tgt_bit  = BYTE_W'(1) << page_ff[2:0];

   // ram port selection
   always_comb begin
      wr_en   = cmd.sweep || cmd.wr_target || cmd.search_take;
      wr_addr = cur_ff[AW-1:0];
      wr_data = '0;
      if (cmd.wr_target) begin
         wr_addr = page_ff[PGW-1:3];
         wr_data = (mode_ff == MODE_MARK) ? (rd_data | tgt_bit) : (rd_data & ~tgt_bit);
      end else if (cmd.search_take) begin
         wr_addr = chk_byte_ff[AW-1:0];
         wr_data = rd_data | (BYTE_W'(1) << hit_bit);
      end
      rd_en   = cmd.rd_target || cmd.search_issue;
      rd_addr = cmd.rd_target ? page_ff[PGW-1:3] : cur_ff[AW-1:0];
   end

   bpa_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (DEPTH)
   ) u_map (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff       <= '0;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         chk_vld_ff <= cmd.search_issue;
         if (cmd.decode) begin
            cur_ff <= is_alloc ? BW'(lo >> 3) : '0;
         end else if (cmd.sweep || cmd.search_issue) begin
            cur_ff <= cur_ff + BW'(1);
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      eff_ff  <= eff_in;
      effr_ff <= effr_in;
      if (cmd.load) begin
         mode_ff <= req_mode;
         pidx_ff <= req_page_index;
         addr_ff <= req_address;
      end
      if (cmd.decode) begin
         page_ff    <= tgt_pg;
         last_ff    <= BW'(hm1 >> 3);
         lo_byte_ff <= BW'(lo >> 3);
         lo_bit_ff  <= lo[2:0];
         hi_bit_ff  <= hm1[2:0];
         case (mode_ff)
            MODE_MARK, MODE_FREE: begin
               res_status_ff <= dec_ok ? ST_OK : ST_RANGE;
               res_has_ff    <= dec_ok;
            end
            MODE_ALLOC, MODE_ALLOC_RSV: begin
               res_status_ff <= empty ? ST_NONE : ST_OK;
               res_has_ff    <= 1'b0;
            end
            default: begin
               res_status_ff <= ST_OK;
               res_has_ff    <= 1'b0;
            end
         endcase
      end
      if (cmd.search_issue) begin
         chk_byte_ff <= cur_ff;
      end
      if (cmd.search_take) begin
         page_ff    <= found_pg;
         res_has_ff <= 1'b1;
      end
      if (cmd.search_none) begin
         res_status_ff <= ST_NONE;
      end
      if (cmd.rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_addr_ff   <= res_has_ff ?
                          base_address + (ADDR_W'(page_ff) << PAGE_SIZE_LOG2) : '0;
         rsp_page_ff   <= res_has_ff ? PIDX_W'(page_ff) : '0;
      end
   end

   assign sts.mode       = mode_ff;
   assign sts.dec_ok     = dec_ok;
   assign sts.dec_empty  = empty;
   assign sts.sweep_last = cur_ff == LAST_BYTE;
   assign sts.issue_done = cur_ff > last_ff;
   assign sts.hit        = hit;
   assign sts.chk_vld    = chk_vld_ff;
   assign sts.rsp_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_page_address = rsp_addr_ff;
   assign rsp_page_number  = rsp_page_ff;

   a_hit_in_range: assert property (@(posedge clock) disable iff (reset)
      hit |-> (EW'(found_pg) >= lo) && (EW'(found_pg) < hi))
      else $error("found page outside the search range");

   a_sweep_in_map: assert property (@(posedge clock) disable iff (reset)
      cmd.sweep |-> cur_ff <= LAST_BYTE)
      else $error("clear sweep beyond the bitmap");

endmodule

FILE: src/bitmap_page_allocator.sv
// bitmap_page_allocator: top level, apb registers and channel wiring
// depends on bpa_pkg, bpa_if, bpa_ram, bpa_ctrl, bpa_datapath
//
// usage
// - req_chan carries one request per transaction: mode (clear, mark, allocate
//   general, allocate reserved, free), page_index for mark, address for free
// - rsp_chan returns exactly one result per request: status, page_address and
//   page_number, in request order
// - apb registers: base_address at 0x0, page_count at 0x4, reserve_count at 0x8;
//   write them only while no request is in flight
// - mark and free read and rewrite one bitmap byte, skipping both when the page is
//   out of range; an allocation scans its range of the bitmap one byte per cycle
//   through the single ram read port until it finds a free page, and an empty
//   range answers without a scan; a clear sweeps every byte
// - one request is worked on at a time; the next one is taken as soon as the
//   previous result sits in the output register
// - reset: a clearing pass writes the bitmap to all free; req_chan.ready stays low
//   until it ends, apb writes are taken throughout
// - a stalled rsp_chan holds the result; a finished request then waits for the
//   output register and no new request is taken

module bitmap_page_allocator import bpa_pkg::*; #(
   parameter int MAX_PAGES      = 4096,
   parameter int PAGE_SIZE_LOG2 = 12
) (
   input  logic              clock,
   input  logic              reset,
   bpa_req_if.sink           req_chan,
   bpa_rsp_if.source         rsp_chan,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output logic              pready
);

   // configuration registers
   logic [ADDR_W-1:0] base_address_ff;
   logic [CNT_W-1:0]  page_count_ff;
   logic [CNT_W-1:0]  reserve_count_ff;
   logic              csr_write;

   bpa_cmd_type       cmd;
   bpa_sts_type       sts;
   logic              ctl_req_ready;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   // register write at the access phase
   always_ff @(posedge clock) begin
      if (reset) begin
         base_address_ff  <= '0;
         page_count_ff    <= PAGE_COUNT_RST;
         reserve_count_ff <= '0;
      end else if (csr_write) begin
         case (paddr[3:2])
            REG_BASE:    base_address_ff  <= pwdata;
            REG_PAGES:   page_count_ff    <= pwdata[CNT_W-1:0];
            REG_RESERVE: reserve_count_ff <= pwdata[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   // read back, unmapped offsets read zero
   always_comb begin
      case (paddr[3:2])
         REG_BASE:    prdata = base_address_ff;
         REG_PAGES:   prdata = CSR_DW'(page_count_ff);
         REG_RESERVE: prdata = CSR_DW'(reserve_count_ff);
         default:     prdata = '0;
      endcase
   end

   // sequencer
   bpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (ctl_req_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   assign req_chan.ready = ctl_req_ready;

   // bitmap, scan and result register
   bpa_datapath #(
      .MAX_PAGES      (MAX_PAGES),
      .PAGE_SIZE_LOG2 (PAGE_SIZE_LOG2)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_mode         (req_chan.mode),
      .req_page_index   (req_chan.page_index),
      .req_address      (req_chan.address),
      .base_address     (base_address_ff),
      .page_count       (page_count_ff),
      .reserve_count    (reserve_count_ff),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .rsp_status       (rsp_chan.status),
      .rsp_page_address (rsp_chan.page_address),
      .rsp_page_number  (rsp_chan.page_number)
   );

endmodule

FILE: sim/bitmap_page_allocator_test.sv
// bitmap_page_allocator_test: self-checking bench for the bitmap page allocator
// runs a directed table, then random request phases against an internal predictor
// depends on bpa_pkg, bpa_if and the allocator rtl under src

module bitmap_page_allocator_test import bpa_pkg::*; ;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_PG    = 4096;
   localparam int PAGE_LOG2 = 12;

   // spare request codes, the block answers them with an all-zero ok result
   localparam logic [MODE_W-1:0] MODE_SPARE_FIRST = 3'd5;
   localparam logic [MODE_W-1:0] MODE_SPARE_LAST  = 3'd7;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [ADDR_W-1:0] page_address;
      logic [PIDX_W-1:0] page_number;
   } page_result_type;

   // one line of the directed table: either a register write or a request,
   // a request with typed_in set carries its expected result in the row itself
   typedef struct packed {
      bit                is_write;
      logic [1:0]        reg_idx;
      logic [CSR_DW-1:0] reg_val;
      logic [MODE_W-1:0] mode;
      logic [PIDX_W-1:0] pidx;
      logic [ADDR_W-1:0] addr;
      bit                typed_in;
      page_result_type   want;
   } stim_row_type;

   logic              clock;
   logic              reset;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [CSR_AW-1:0] paddr;
   logic [CSR_DW-1:0] pwdata;
   logic [CSR_DW-1:0] prdata;
   logic              pready;

   bpa_req_if req_chan ();
   bpa_rsp_if rsp_chan ();

   bitmap_page_allocator #(
      .MAX_PAGES      (MAX_PG),
      .PAGE_SIZE_LOG2 (PAGE_LOG2)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   // predictor state: its own copy of the bitmap and the three registers
   bit   [MAX_PG-1:0] page_used;
   logic [ADDR_W-1:0] base_reg;
   logic [CNT_W-1:0]  pages_reg;
   logic [CNT_W-1:0]  reserve_reg;

   page_result_type pending_results[$];
   stim_row_type    stim_rows[$];
   int              failures;
   int              req_gap_pct;
   int              rsp_stall_pct;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // hard stop well past the slowest legal run, clearing pass included
   initial begin
      #12_000_000;
      $display("Test completed with failures");
      $finish;
   end

   // page_count is clamped to the bitmap size
   function automatic int effective_pages();
      return (pages_reg > MAX_PG) ? MAX_PG : int'(pages_reg);
   endfunction

   // address of a page, wrapping at 32 bits
   function automatic logic [ADDR_W-1:0] page_base(input int pg);
      return base_reg + (ADDR_W'(pg) << PAGE_LOG2);
   endfunction

   // applies one request to the predictor bitmap and returns the result it yields
   function automatic page_result_type next_page_result(input logic [MODE_W-1:0] mode,
                                                        input logic [PIDX_W-1:0] pidx,
                                                        input logic [ADDR_W-1:0] addr);
      page_result_type   r;
      int                lim;
      int                rsv;
      int                lo;
      int                hi;
      int                pg;
      bit                found;
      logic [ADDR_W-1:0] offset;
      r      = '0;
      lim    = effective_pages();
      rsv    = (reserve_reg > lim) ? lim : int'(reserve_reg);
      found  = 1'b0;
      pg     = 0;
      offset = addr - base_reg;
      case (mode)
         MODE_CLEAR: page_used = '0;
         MODE_MARK: begin
            if (pidx >= lim) begin
               r.status = ST_RANGE;
            end else begin
               page_used[pidx] = 1'b1;
               r = '{ST_OK, page_base(int'(pidx)), pidx};
            end
         end
         MODE_ALLOC, MODE_ALLOC_RSV: begin
            // general range sits above the reserved pages
            lo = (mode == MODE_ALLOC) ? rsv : 0;
            hi = (mode == MODE_ALLOC) ? lim : rsv;
            for (int p = lo; p < hi && !found; p++) begin
               if (!page_used[p]) begin
                  found = 1'b1;
                  pg    = p;
               end
            end
            if (found) begin
               page_used[pg] = 1'b1;
               r = '{ST_OK, page_base(pg), PIDX_W'(pg)};
            end else begin
               r.status = ST_NONE;
            end
         end
         MODE_FREE: begin
            if (addr < base_reg || (offset >> PAGE_LOG2) >= lim) begin
               r.status = ST_RANGE;
            end else begin
               pg = int'(offset >> PAGE_LOG2);
               page_used[pg] = 1'b0;
               r = '{ST_OK, page_base(pg), PIDX_W'(pg)};
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic void add_cfg(input logic [1:0] idx, input logic [CSR_DW-1:0] value);
      stim_row_type row;
      row          = '0;
      row.is_write = 1'b1;
      row.reg_idx  = idx;
      row.reg_val  = value;
      stim_rows.push_back(row);
   endfunction

   function automatic void add_req(input logic [MODE_W-1:0] mode,
                                   input logic [PIDX_W-1:0] pidx,
                                   input logic [ADDR_W-1:0] addr);
      stim_row_type row;
      row      = '0;
      row.mode = mode;
      row.pidx = pidx;
      row.addr = addr;
      stim_rows.push_back(row);
   endfunction

   function automatic void add_chk(input logic [MODE_W-1:0] mode,
                                   input logic [PIDX_W-1:0] pidx,
                                   input logic [ADDR_W-1:0] addr,
                                   input logic [STAT_W-1:0] status,
                                   input logic [ADDR_W-1:0] page_address,
                                   input logic [PIDX_W-1:0] page_number);
      stim_row_type row;
      row          = '0;
      row.mode     = mode;
      row.pidx     = pidx;
      row.addr     = addr;
      row.typed_in = 1'b1;
      row.want     = '{status, page_address, page_number};
      stim_rows.push_back(row);
   endfunction

   function automatic void compare_field(input string name, input logic [ADDR_W-1:0] want,
                                         input logic [ADDR_W-1:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %h actual %h", $time, name, want, got);
         failures++;
      end
   endfunction

   task automatic wait_for_results();
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // one request transaction; the expectation is queued at the accepting edge
   task automatic issue_request(input logic [MODE_W-1:0] mode,
                                input logic [PIDX_W-1:0] pidx,
                                input logic [ADDR_W-1:0] addr,
                                input bit typed_in, input page_result_type want);
      page_result_type predicted;
      if ($urandom_range(0, 99) < req_gap_pct) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.mode       <= mode;
      req_chan.page_index <= pidx;
      req_chan.address    <= addr;
      do @(posedge clock); while (!req_chan.ready);
      // the predictor always runs so its bitmap tracks typed-in rows as well
      predicted = next_page_result(mode, pidx, addr);
      pending_results.push_back(typed_in ? want : predicted);
   endtask

   // apb write, only once the allocator has returned every result
   task automatic write_register(input logic [1:0] idx, input logic [CSR_DW-1:0] value);
      req_chan.valid <= 1'b0;
      wait_for_results();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_AW'({idx, 2'b00});
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         REG_BASE:    base_reg    = value;
         REG_PAGES:   pages_reg   = value[CNT_W-1:0];
         REG_RESERVE: reserve_reg = value[CNT_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // random request, mostly well-formed for the current window, with some noise
   task automatic random_request();
      int                pick;
      int                lim;
      logic [MODE_W-1:0] mode;
      logic [PIDX_W-1:0] pidx;
      logic [ADDR_W-1:0] addr;
      lim  = effective_pages();
      pidx = PIDX_W'($urandom);
      addr = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 34) begin
         mode = MODE_ALLOC;
      end else if (pick < 52) begin
         mode = MODE_ALLOC_RSV;
      end else if (pick < 70) begin
         // free somewhere inside or just past the managed window
         mode = MODE_FREE;
         addr = base_reg + (ADDR_W'($urandom_range(0, lim + 2)) << PAGE_LOG2)
                + ADDR_W'($urandom_range(0, (1 << PAGE_LOG2) - 1));
      end else if (pick < 74) begin
         mode = MODE_FREE;
         addr = base_reg - ADDR_W'($urandom_range(1, 1 << PAGE_LOG2));
      end else if (pick < 86) begin
         mode = MODE_MARK;
         pidx = PIDX_W'($urandom_range(0, lim + 1));
      end else if (pick < 89) begin
         mode = MODE_CLEAR;
      end else if (pick < 92) begin
         mode = MODE_W'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
      end else if (pick < 96) begin
         mode = MODE_FREE;
      end else begin
         mode = MODE_MARK;
      end
      issue_request(mode, pidx, addr, 1'b0, '0);
   endtask

   // result checker: every accepted result against the oldest expectation
   always @(posedge clock) begin : check_results
      page_result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t ns: result with nothing expected, status %h page_address %h",
                     $time, rsp_chan.status, rsp_chan.page_address);
            failures++;
         end else begin
            want = pending_results.pop_front();
            compare_field("status", ADDR_W'(want.status), ADDR_W'(rsp_chan.status));
            compare_field("page_address", want.page_address, rsp_chan.page_address);
            compare_field("page_number", ADDR_W'(want.page_number),
                          ADDR_W'(rsp_chan.page_number));
         end
      end
   end

   // result side back-pressure in random bursts
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if ($urandom_range(0, 99) < rsp_stall_pct) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
      end
   end

   initial begin
      logic [ADDR_W-1:0] cfg_base;
      int                cfg_pages;
      int                cfg_rsv;
      int                count;
      reset               <= 1'b1;
      psel                <= 1'b0;
      penable             <= 1'b0;
      pwrite              <= 1'b0;
      paddr               <= '0;
      pwdata              <= '0;
      req_chan.valid      <= 1'b0;
      req_chan.mode       <= MODE_CLEAR;
      req_chan.page_index <= '0;
      req_chan.address    <= '0;
      failures      = 0;
      req_gap_pct   = 20;
      rsp_stall_pct = 20;
      page_used     = '0;
      base_reg      = '0;
      pages_reg     = PAGE_COUNT_RST;
      reserve_reg   = '0;

      // directed table, reset registers first: base 0, all pages general
      add_chk(MODE_ALLOC, 12'd0, 32'h0, ST_OK, 32'h0000_0000, 12'd0);
      add_chk(MODE_ALLOC, 12'd0, 32'h0, ST_OK, 32'h0000_1000, 12'd1);
      // reserved range is empty after reset
      add_chk(MODE_ALLOC_RSV, 12'd0, 32'h0, ST_NONE, 32'h0, 12'd0);
      add_chk(MODE_MARK, 12'hFFF, 32'h0, ST_OK, 32'h00FF_F000, 12'hFFF);
      // marking a page that is already used still reports ok
      add_chk(MODE_MARK, 12'd0, 32'h0, ST_OK, 32'h0, 12'd0);
      add_chk(MODE_FREE, 12'd0, 32'h0000_1FFF, ST_OK, 32'h0000_1000, 12'd1);
      // second free of the same page is harmless
      add_chk(MODE_FREE, 12'd0, 32'h0000_1000, ST_OK, 32'h0000_1000, 12'd1);
      add_chk(MODE_FREE, 12'hFFF, 32'hFFFF_FFFF, ST_RANGE, 32'h0, 12'd0);
      add_chk(MODE_FREE, 12'd0, 32'h00FF_FFFF, ST_OK, 32'h00FF_F000, 12'hFFF);
      add_chk(MODE_FREE, 12'd0, 32'h0100_0000, ST_RANGE, 32'h0, 12'd0);
      add_chk(MODE_SPARE_FIRST, 12'hFFF, 32'hFFFF_FFFF, ST_OK, 32'h0, 12'd0);
      add_chk(MODE_SPARE_LAST, 12'd0, 32'h0, ST_OK, 32'h0, 12'd0);
      add_req(MODE_ALLOC, 12'd0, 32'h0);
      add_chk(MODE_CLEAR, 12'hFFF, 32'hFFFF_FFFF, ST_OK, 32'h0, 12'd0);
      // small window with a reserved low part
      add_cfg(REG_BASE, 32'h8000_0000);
      add_cfg(REG_PAGES, 32'd20);
      add_cfg(REG_RESERVE, 32'd4);
      add_chk(MODE_MARK, 12'd20, 32'h0, ST_RANGE, 32'h0, 12'd0);
      add_chk(MODE_ALLOC_RSV, 12'd0, 32'h0, ST_OK, 32'h8000_0000, 12'd0);
      add_chk(MODE_ALLOC, 12'd0, 32'h0, ST_OK, 32'h8000_4000, 12'd4);
      // address below the base
      add_chk(MODE_FREE, 12'd0, 32'h7FFF_FFFF, ST_RANGE, 32'h0, 12'd0);
      add_chk(MODE_FREE, 12'd0, 32'h8001_3FFF, ST_OK, 32'h8001_3000, 12'd19);
      add_chk(MODE_FREE, 12'd0, 32'h8001_4000, ST_RANGE, 32'h0, 12'd0);
      // oversized counts clamp: reserve swallows everything, general is empty
      add_cfg(REG_PAGES, 32'hFFFF_FFFF);
      add_cfg(REG_RESERVE, 32'h0000_1FFF);
      add_chk(MODE_ALLOC, 12'd0, 32'h0, ST_NONE, 32'h0, 12'd0);
      add_req(MODE_ALLOC_RSV, 12'd0, 32'h0);
      // page addresses wrap past the top of the address space
      add_cfg(REG_BASE, 32'hFFFF_F000);
      add_cfg(REG_PAGES, 32'd4);
      add_cfg(REG_RESERVE, 32'd0);
      add_req(MODE_MARK, 12'd3, 32'h0);
      add_chk(MODE_FREE, 12'd0, 32'hFFFF_FFFF, ST_OK, 32'hFFFF_F000, 12'd0);
      add_chk(MODE_CLEAR, 12'd0, 32'h0, ST_OK, 32'h0, 12'd0);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // request ready stays low through the clearing pass, the handshake covers it
      foreach (stim_rows[i]) begin
         if (stim_rows[i].is_write) begin
            write_register(stim_rows[i].reg_idx, stim_rows[i].reg_val);
         end else begin
            issue_request(stim_rows[i].mode, stim_rows[i].pidx, stim_rows[i].addr,
                          stim_rows[i].typed_in, stim_rows[i].want);
         end
      end

      // random phases, each under its own register setting; small windows keep
      // the first-fit scans short, a few phases use the full bitmap
      for (int ph = 0; ph < 14; ph++) begin
         case (ph)
            0: begin
               cfg_base = 32'h0001_0000; cfg_pages = 64; cfg_rsv = 16; count = 90;
            end
            1: begin
               cfg_base = 32'hFFFF_F000; cfg_pages = 24; cfg_rsv = 0; count = 90;
            end
            2: begin
               cfg_base = 32'hFFFF_FFFF; cfg_pages = MAX_PG; cfg_rsv = MAX_PG; count = 40;
            end
            3: begin
               cfg_base = 32'h0; cfg_pages = 0; cfg_rsv = 0; count = 30;
            end
            4: begin
               cfg_base = 32'h1234_5000; cfg_pages = 8191; cfg_rsv = 100; count = 60;
            end
            default: begin
               cfg_base  = $urandom;
               cfg_pages = $urandom_range(1, 160);
               cfg_rsv   = $urandom_range(0, cfg_pages + 8);
               count     = 95;
            end
         endcase
         write_register(REG_BASE, cfg_base);
         write_register(REG_PAGES, CSR_DW'(cfg_pages));
         write_register(REG_RESERVE, CSR_DW'(cfg_rsv));
         for (int n = 0; n < count; n++) begin
            // idling level changes every 25 transactions; the last phase runs flat out
            if (n % 25 == 0) begin
               if (ph == 13) begin
                  req_gap_pct   = 0;
                  rsp_stall_pct = 0;
               end else begin
                  case ($urandom_range(0, 2))
                     0: begin req_gap_pct = 0;  rsp_stall_pct = 0;  end
                     1: begin req_gap_pct = 10; rsp_stall_pct = 10; end
                     default: begin req_gap_pct = 35; rsp_stall_pct = 35; end
                  endcase
               end
            end
            random_request();
         end
      end

      req_chan.valid <= 1'b0;
      wait_for_results();
      repeat (30) @(posedge clock);
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
